>>> sv/wms_pkg.sv
// ----------------------------------------------------------------------------
// wms_pkg
// Shared types, codes and table defaults for the waypoint motion sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package wms_pkg;

    localparam int KIND_W   = 3;
    localparam int AMOUNT_W = 16;
    localparam int ENTRY_W  = KIND_W + AMOUNT_W;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_FWD   = 3'd1,
        CMD_BACK  = 3'd2,
        CMD_LEFT  = 3'd3,
        CMD_RIGHT = 3'd4,
        CMD_STOP  = 3'd5
    } motor_cmd_t;

    localparam logic [1:0] FUNC_STEP  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_RESET = 2'd2;

    localparam logic [2:0] KIND_STRAIGHT = 3'd0;
    localparam logic [2:0] KIND_BACK     = 3'd1;
    localparam logic [2:0] KIND_LEFT     = 3'd2;
    localparam logic [2:0] KIND_RIGHT    = 3'd3;

    localparam logic [1:0] CFG_TASK_COUNT   = 2'd0;
    localparam logic [1:0] CFG_PAUSE_TICKS  = 2'd1;
    localparam logic [1:0] CFG_MM_SCALE     = 2'd2;
    localparam logic [1:0] CFG_DEGREE_SCALE = 2'd3;

    localparam logic [3:0]  TASK_COUNT_RST   = 4'd5;
    localparam logic [15:0] PAUSE_TICKS_RST  = 16'd150;
    localparam logic [15:0] MM_SCALE_RST     = 16'd12516;
    localparam logic [15:0] DEGREE_SCALE_RST = 16'd8738;

    localparam logic [15:0] ROUND_HALF = 16'h8000;

    typedef struct packed {
        motor_cmd_t  motor_cmd;
        logic        finished;
        logic [2:0]  task_position;
        logic        running;
        logic        pausing;
    } result_t;

    function automatic logic [ENTRY_W-1:0] default_entry(input logic [7:0] idx);
        logic [ENTRY_W-1:0] e;
        case (idx)
            8'd0:    e = {KIND_STRAIGHT, 16'd425};
            8'd1:    e = {KIND_RIGHT,    16'd150};
            8'd2:    e = {KIND_STRAIGHT, 16'd250};
            8'd3:    e = {KIND_LEFT,     16'd45};
            8'd4:    e = {KIND_STRAIGHT, 16'd160};
            default: e = '0;
        endcase
        return e;
    endfunction

endpackage

`default_nettype wire

>>> sv/wms_ram.sv
// ----------------------------------------------------------------------------
// wms_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module wms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                    clk,
    input  wire logic                    we,
    input  wire logic [AW-1:0]           waddr,
    input  wire logic [WIDTH-1:0]        wdata,
    input  wire logic [AW-1:0]           raddr,
    output logic      [WIDTH-1:0]        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> sv/wms_out_queue.sv
// ----------------------------------------------------------------------------
// wms_out_queue
// Two-entry result queue; decouples the step logic from result stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module wms_out_queue
    import wms_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_data,
    output logic         full,
    output logic         valid,
    input  wire logic    stall,
    output result_t      head
);

    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    result_t    head_reg;
    result_t    tail_reg;
    logic       pop;

    assign pop   = (cnt_reg != 2'd0) && !stall;
    assign full  = (cnt_reg == 2'd2);
    assign valid = (cnt_reg != 2'd0);
    assign head  = head_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (cnt_reg == 2'd2)
            begin
                head_reg <= tail_reg;
            end
            else if (push)
            begin
                head_reg <= push_data;
            end
        end
        else if (push)
        begin
            if (cnt_reg == 2'd0)
            begin
                head_reg <= push_data;
            end
            else
            begin
                tail_reg <= push_data;
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/waypoint_motion_sequencer_core.sv
// ----------------------------------------------------------------------------
// waypoint_motion_sequencer_core
// Runs a table of drive and turn tasks against wheel encoder counts.
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+---------------------------
//   step     | in        | step_valid / step_stall   | func, dist_*, tick_now, entry_*
//   result   | out       | result_valid/result_stall | motor_cmd, finished, status
//   cfg      | in        | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// One item per cycle while step_stall is low; each item is decided in the cycle
// it is accepted, from a task table entry registered out of RAM ahead of use at the next task index.
// Results land in a two-entry queue; step_stall rises only when it is full.
// Reset restores the default route through per-entry valid bits; no sweep.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module waypoint_motion_sequencer_core
    import wms_pkg::*;
#(
    parameter int MAX_TASKS = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        step_valid,
    output logic             step_stall,
    input  wire logic [1:0]  func,
    input  wire logic [31:0] dist_left,
    input  wire logic [31:0] dist_right,
    input  wire logic [31:0] tick_now,
    input  wire logic [2:0]  entry_index,
    input  wire logic [2:0]  entry_type,
    input  wire logic [15:0] entry_value,

    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [2:0]       motor_cmd,
    output logic             finished,
    output logic [2:0]       task_position,
    output logic             running,
    output logic             pausing,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam int CW    = (CNT_W > 4) ? CNT_W : 4;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_TASKS);

    logic [3:0]  task_count_reg;
    logic [15:0] pause_ticks_reg;
    logic [15:0] mm_scale_reg;
    logic [15:0] degree_scale_reg;

    logic [31:0]      goal_left_reg, goal_left_next;
    logic [31:0]      goal_right_reg, goal_right_next;
    logic [IDX_W-1:0] active_index_reg, active_index_next;
    logic             active_reg, active_next;
    logic             pause_reg, pause_next;
    logic [31:0]      pause_begin_reg, pause_begin_next;

    logic [MAX_TASKS-1:0] valid_reg;
    logic                 rd_valid_reg;
    logic                 byp_reg;
    logic [ENTRY_W-1:0]   byp_data_reg;

    logic               step_fire;
    logic               tbl_we;
    logic [IDX_W-1:0]   tbl_waddr;
    logic [ENTRY_W-1:0] tbl_wdata;
    logic [ENTRY_W-1:0] ram_q;
    logic [ENTRY_W-1:0] entry;
    logic [KIND_W-1:0]  kind;
    logic [AMOUNT_W-1:0] amount;

    logic [15:0] scale;
    logic [31:0] product;
    logic [31:0] rounded;
    logic [31:0] add;
    motor_cmd_t  begin_cmd;
    logic [31:0] begin_left;
    logic [31:0] begin_right;

    logic [CW-1:0] count_eff;
    logic [CW-1:0] idx_ext;
    logic [CW-1:0] idx_inc;
    logic [31:0]   elapsed;
    logic          kind_ok;

    motor_cmd_t cmd;
    logic       fin;
    result_t    res;
    result_t    head;
    logic       q_full;
    logic [IDX_W+2:0] pos_ext;

    assign cfg_ready  = 1'b1;
    assign step_stall = q_full;
    assign step_fire  = step_valid && !step_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            task_count_reg   <= TASK_COUNT_RST;
            pause_ticks_reg  <= PAUSE_TICKS_RST;
            mm_scale_reg     <= MM_SCALE_RST;
            degree_scale_reg <= DEGREE_SCALE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TASK_COUNT:   task_count_reg   <= cfg_data[3:0];
                CFG_PAUSE_TICKS:  pause_ticks_reg  <= cfg_data;
                CFG_MM_SCALE:     mm_scale_reg     <= cfg_data;
                CFG_DEGREE_SCALE: degree_scale_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign tbl_we    = step_fire && (func == FUNC_WRITE) && (32'(entry_index) < MAX_TASKS);
    assign tbl_waddr = IDX_W'(entry_index);
    assign tbl_wdata = {entry_type, entry_value};

    wms_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TASKS)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (active_index_next),
        .rdata (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            byp_reg      <= 1'b0;
        end
        else
        begin
            if (tbl_we)
            begin
                valid_reg[tbl_waddr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[active_index_next];
            byp_reg      <= tbl_we && (tbl_waddr == active_index_next);
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= tbl_wdata;
    end

    always_comb
    begin
        if (byp_reg)
        begin
            entry = byp_data_reg;
        end
        else if (rd_valid_reg)
        begin
            entry = ram_q;
        end
        else
        begin
            entry = default_entry(8'(active_index_reg));
        end
    end

    assign kind    = entry[ENTRY_W-1 -: KIND_W];
    assign amount  = entry[AMOUNT_W-1:0];
    assign kind_ok = (kind <= KIND_RIGHT);

    assign scale   = kind[1] ? degree_scale_reg : mm_scale_reg;
    assign product = {16'd0, amount} * {16'd0, scale};
    assign rounded = product + {16'd0, ROUND_HALF};
    assign add     = {16'd0, rounded[31:16]};

    always_comb
    begin
        begin_left  = dist_left + add;
        begin_right = dist_right + add;
        case (kind)
            KIND_STRAIGHT: begin_cmd = CMD_FWD;
            KIND_BACK:     begin_cmd = CMD_BACK;
            KIND_LEFT:     begin_cmd = CMD_LEFT;
            KIND_RIGHT:    begin_cmd = CMD_RIGHT;
            default:
            begin
                begin_cmd   = CMD_STOP;
                begin_left  = 32'd0;
                begin_right = 32'd0;
            end
        endcase
    end

    assign count_eff = (CW'(task_count_reg) > MAX_C) ? MAX_C : CW'(task_count_reg);
    assign idx_ext   = CW'(active_index_reg);
    assign idx_inc   = idx_ext + CW'(1);
    assign elapsed   = tick_now - pause_begin_reg;

    always_comb
    begin
        goal_left_next    = goal_left_reg;
        goal_right_next   = goal_right_reg;
        active_index_next = active_index_reg;
        active_next       = active_reg;
        pause_next        = pause_reg;
        pause_begin_next  = pause_begin_reg;
        cmd               = CMD_NONE;
        fin               = 1'b0;
        if (step_fire)
        begin
            case (func)
                FUNC_RESET:
                begin
                    active_next       = 1'b0;
                    pause_next        = 1'b0;
                    active_index_next = '0;
                end
                FUNC_STEP:
                begin
                    if (pause_reg)
                    begin
                        if (elapsed >= {16'd0, pause_ticks_reg})
                        begin
                            pause_next      = 1'b0;
                            cmd             = begin_cmd;
                            goal_left_next  = begin_left;
                            goal_right_next = begin_right;
                        end
                    end
                    else if (!active_reg)
                    begin
                        if (count_eff == '0)
                        begin
                            cmd               = CMD_STOP;
                            fin               = 1'b1;
                            active_index_next = '0;
                        end
                        else
                        begin
                            active_next     = 1'b1;
                            cmd             = begin_cmd;
                            goal_left_next  = begin_left;
                            goal_right_next = begin_right;
                        end
                    end
                    else if (idx_ext >= count_eff)
                    begin
                        cmd               = CMD_STOP;
                        fin               = 1'b1;
                        active_next       = 1'b0;
                        pause_next        = 1'b0;
                        active_index_next = '0;
                    end
                    else if (kind_ok && ((dist_left >= goal_left_reg) ||
                                         (dist_right >= goal_right_reg)))
                    begin
                        cmd = CMD_STOP;
                        if (idx_inc >= count_eff)
                        begin
                            fin               = 1'b1;
                            active_next       = 1'b0;
                            pause_next        = 1'b0;
                            active_index_next = '0;
                        end
                        else
                        begin
                            active_index_next = IDX_W'(idx_inc);
                            pause_next        = 1'b1;
                            pause_begin_next  = tick_now;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_left_reg    <= 32'd0;
            goal_right_reg   <= 32'd0;
            active_index_reg <= '0;
            active_reg       <= 1'b0;
            pause_reg        <= 1'b0;
            pause_begin_reg  <= 32'd0;
        end
        else
        begin
            goal_left_reg    <= goal_left_next;
            goal_right_reg   <= goal_right_next;
            active_index_reg <= active_index_next;
            active_reg       <= active_next;
            pause_reg        <= pause_next;
            pause_begin_reg  <= pause_begin_next;
        end
    end

    assign pos_ext = {3'd0, active_index_next};

    always_comb
    begin
        res.motor_cmd     = cmd;
        res.finished      = fin;
        res.task_position = active_next ? pos_ext[2:0] : 3'd0;
        res.running       = active_next;
        res.pausing       = pause_next;
    end

    wms_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step_fire),
        .push_data (res),
        .full      (q_full),
        .valid     (result_valid),
        .stall     (result_stall),
        .head      (head)
    );

    assign motor_cmd     = head.motor_cmd;
    assign finished      = head.finished;
    assign task_position = head.task_position;
    assign running       = head.running;
    assign pausing       = head.pausing;

endmodule

`default_nettype wire

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the waypoint motion sequencer core.
// Sends step, table-write, reset and unused items, writes all four registers
// between phases, and predicts every result item from a behavioral copy of
// the task sequencer. Results are compared field by field in order, under
// random idling on both sides and one long hold-off on the result side.
// ----------------------------------------------------------------------------
module tb;
    import wms_pkg::*;

    localparam int         TABLE_DEPTH  = 8;
    localparam int         HOLD_LEN     = 60;
    localparam int         RANDOM_ITEMS = 2000;
    localparam int         PHASE_LEN    = 250;
    localparam logic [1:0] FUNC_SPARE   = 2'd3;
    localparam logic [2:0] KIND_BAD     = 3'd7;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] enc_l;
        logic [31:0] enc_r;
        logic [31:0] tick;
        logic [2:0]  slot;
        logic [2:0]  kind;
        logic [15:0] amount;
    } step_item_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        step_valid   = 1'b0;
    logic        step_stall;
    logic [1:0]  func         = FUNC_STEP;
    logic [31:0] dist_left    = '0;
    logic [31:0] dist_right   = '0;
    logic [31:0] tick_now     = '0;
    logic [2:0]  entry_index  = '0;
    logic [2:0]  entry_type   = '0;
    logic [15:0] entry_value  = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [2:0]  motor_cmd;
    logic        finished;
    logic [2:0]  task_position;
    logic        running;
    logic        pausing;
    logic        cfg_valid    = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index    = '0;
    logic [15:0] cfg_data     = '0;

    // sequencer copy used for prediction
    logic [3:0]  p_count;
    logic [15:0] p_pause;
    logic [15:0] p_mm_scale;
    logic [15:0] p_deg_scale;
    logic [2:0]  p_kind [TABLE_DEPTH];
    logic [15:0] p_amount [TABLE_DEPTH];
    logic [31:0] p_goal_l;
    logic [31:0] p_goal_r;
    logic [31:0] p_pause_from;
    logic [3:0]  p_task;
    logic        p_active;
    logic        p_paused;

    result_t     expected_status_q[$];
    int          errors      = 0;
    int          gap_pct     = 6;
    int          stall_pct   = 6;
    int          holds_asked = 0;
    int          holds_seen;
    int          hold_left;
    logic [31:0] wheel_l     = '0;
    logic [31:0] wheel_r     = '0;
    logic [31:0] ms_tick     = '0;

    waypoint_motion_sequencer_core #(
        .MAX_TASKS(TABLE_DEPTH)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_valid   (step_valid),
        .step_stall   (step_stall),
        .func         (func),
        .dist_left    (dist_left),
        .dist_right   (dist_right),
        .tick_now     (tick_now),
        .entry_index  (entry_index),
        .entry_type   (entry_type),
        .entry_value  (entry_value),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .motor_cmd    (motor_cmd),
        .finished     (finished),
        .task_position(task_position),
        .running      (running),
        .pausing      (pausing),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [31:0] scale_amount(input logic [15:0] amount,
                                                 input logic [15:0] scale);
        logic [32:0] prod;
        prod = 33'(amount) * 33'(scale) + 33'd32768;
        return {15'd0, prod[32:16]};
    endfunction

    function automatic void seq_idle();
        p_active = 1'b0;
        p_paused = 1'b0;
        p_task   = '0;
    endfunction

    function automatic motor_cmd_t start_task(input logic [31:0] l, input logic [31:0] r);
        logic [2:0]  slot;
        logic [31:0] add;
        motor_cmd_t  cmd;
        slot = p_task[2:0];
        add  = '0;
        cmd  = CMD_STOP;
        case (p_kind[slot])
            KIND_STRAIGHT:
            begin
                cmd = CMD_FWD;
                add = scale_amount(p_amount[slot], p_mm_scale);
            end
            KIND_BACK:
            begin
                cmd = CMD_BACK;
                add = scale_amount(p_amount[slot], p_mm_scale);
            end
            KIND_LEFT:
            begin
                cmd = CMD_LEFT;
                add = scale_amount(p_amount[slot], p_deg_scale);
            end
            KIND_RIGHT:
            begin
                cmd = CMD_RIGHT;
                add = scale_amount(p_amount[slot], p_deg_scale);
            end
            default:
            begin
                p_goal_l = '0;
                p_goal_r = '0;
                return CMD_STOP;
            end
        endcase
        p_goal_l = l + add;
        p_goal_r = r + add;
        return cmd;
    endfunction

    function automatic result_t sequencer_step(input step_item_t it);
        logic [3:0] used;
        motor_cmd_t cmd;
        logic       fin;
        result_t    res;
        used = (p_count > 4'd8) ? 4'd8 : p_count;
        cmd  = CMD_NONE;
        fin  = 1'b0;
        case (it.func)
            FUNC_WRITE:
            begin
                p_kind[it.slot]   = it.kind;
                p_amount[it.slot] = it.amount;
            end
            FUNC_RESET: seq_idle();
            FUNC_STEP:
            begin
                if (p_paused)
                begin
                    if (32'(it.tick - p_pause_from) >= {16'd0, p_pause})
                    begin
                        p_paused = 1'b0;
                        cmd = start_task(it.enc_l, it.enc_r);
                    end
                end
                else if (!p_active)
                begin
                    if (used == 4'd0)
                    begin
                        cmd = CMD_STOP;
                        fin = 1'b1;
                        seq_idle();
                    end
                    else
                    begin
                        p_active = 1'b1;
                        p_task   = '0;
                        cmd = start_task(it.enc_l, it.enc_r);
                    end
                end
                else if (p_task >= used)
                begin
                    cmd = CMD_STOP;
                    fin = 1'b1;
                    seq_idle();
                end
                else if (p_kind[p_task[2:0]] <= KIND_RIGHT &&
                         (it.enc_l >= p_goal_l || it.enc_r >= p_goal_r))
                begin
                    p_task = p_task + 4'd1;
                    cmd = CMD_STOP;
                    if (p_task >= used)
                    begin
                        fin = 1'b1;
                        seq_idle();
                    end
                    else
                    begin
                        p_paused     = 1'b1;
                        p_pause_from = it.tick;
                    end
                end
            end
            default: ;
        endcase
        res.motor_cmd     = cmd;
        res.finished      = fin;
        res.task_position = p_active ? p_task[2:0] : 3'd0;
        res.running       = p_active;
        res.pausing       = p_paused;
        return res;
    endfunction

    always @(posedge clk)
    begin : check_results
        result_t    got;
        result_t    want;
        step_item_t seen;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                got.motor_cmd     = motor_cmd_t'(motor_cmd);
                got.finished      = finished;
                got.task_position = task_position;
                got.running       = running;
                got.pausing       = pausing;
                if (expected_status_q.size() == 0)
                begin
                    if (errors < 10)
                        $display("extra result item: cmd %0d fin %0b pos %0d run %0b pause %0b",
                                 got.motor_cmd, got.finished, got.task_position,
                                 got.running, got.pausing);
                    errors++;
                end
                else
                begin
                    want = expected_status_q.pop_front();
                    if (got.motor_cmd !== want.motor_cmd || got.finished !== want.finished ||
                        got.task_position !== want.task_position ||
                        got.running !== want.running || got.pausing !== want.pausing)
                    begin
                        if (errors < 10)
                        begin
                            $write("mismatch (exp/act): cmd %0d/%0d fin %0b/%0b pos %0d/%0d",
                                   want.motor_cmd, got.motor_cmd, want.finished, got.finished,
                                   want.task_position, got.task_position);
                            $display(" run %0b/%0b pause %0b/%0b",
                                     want.running, got.running, want.pausing, got.pausing);
                        end
                        errors++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_TASK_COUNT:   p_count     = cfg_data[3:0];
                    CFG_PAUSE_TICKS:  p_pause     = cfg_data;
                    CFG_MM_SCALE:     p_mm_scale  = cfg_data;
                    CFG_DEGREE_SCALE: p_deg_scale = cfg_data;
                    default: ;
                endcase
            end
            if (step_valid && !step_stall)
            begin
                seen.func   = func;
                seen.enc_l  = dist_left;
                seen.enc_r  = dist_right;
                seen.tick   = tick_now;
                seen.slot   = entry_index;
                seen.kind   = entry_type;
                seen.amount = entry_value;
                expected_status_q.push_back(sequencer_step(seen));
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            hold_left    <= 0;
            holds_seen   <= 0;
        end
        else if (holds_seen != holds_asked)
        begin
            holds_seen   <= holds_asked;
            hold_left    <= HOLD_LEN;
            result_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left    <= hold_left - 1;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
        end
    end

    function automatic step_item_t rand_item(input logic [1:0] f);
        step_item_t it;
        it.func   = f;
        it.enc_l  = $urandom;
        it.enc_r  = $urandom;
        it.tick   = $urandom;
        it.slot   = 3'($urandom_range(7));
        it.kind   = 3'($urandom_range(7));
        it.amount = 16'($urandom_range(65535));
        return it;
    endfunction

    function automatic step_item_t mk_step(input logic [31:0] l, input logic [31:0] r,
                                           input logic [31:0] t);
        step_item_t it;
        it = rand_item(FUNC_STEP);
        it.enc_l = l;
        it.enc_r = r;
        it.tick  = t;
        return it;
    endfunction

    function automatic step_item_t mk_entry(input logic [2:0] slot, input logic [2:0] kind,
                                            input logic [15:0] amount);
        step_item_t it;
        it = rand_item(FUNC_WRITE);
        it.slot   = slot;
        it.kind   = kind;
        it.amount = amount;
        return it;
    endfunction

    // advance wheels and clock, with rare jumps that wrap the counters
    function automatic step_item_t next_step();
        wheel_l += ($urandom_range(99) < 3) ? $urandom : $urandom_range(0, 40);
        wheel_r += ($urandom_range(99) < 3) ? $urandom : $urandom_range(0, 40);
        ms_tick += ($urandom_range(99) < 3) ? $urandom : $urandom_range(0, 30);
        return mk_step(wheel_l, wheel_r, ms_tick);
    endfunction

    task automatic send_item(input step_item_t it);
        if (gap_pct != 0 && $urandom_range(99) < gap_pct)
        begin
            step_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        step_valid  <= 1'b1;
        func        <= it.func;
        dist_left   <= it.enc_l;
        dist_right  <= it.enc_r;
        tick_now    <= it.tick;
        entry_index <= it.slot;
        entry_type  <= it.kind;
        entry_value <= it.amount;
        @(posedge clk);
        while (step_stall) @(posedge clk);
    endtask

    task automatic wait_idle();
        step_valid <= 1'b0;
        @(posedge clk);
        while (expected_status_q.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic t_default_route();
        send_item(mk_step(32'd0, 32'd0, 32'd0));
        send_item(mk_step(32'd80, 32'd0, 32'd10));
        send_item(mk_step(32'd81, 32'd5, 32'd20));
        send_item(mk_step(32'd90, 32'd90, 32'd169));
        send_item(mk_step(32'd90, 32'd90, 32'd170));
        send_item(mk_step(32'd100, 32'd110, 32'd171));
        send_item(rand_item(FUNC_RESET));
        send_item(rand_item(FUNC_SPARE));
    endtask

    task automatic t_extremes();
        write_reg(CFG_PAUSE_TICKS, 16'd0);
        write_reg(CFG_MM_SCALE, 16'hFFFF);
        write_reg(CFG_DEGREE_SCALE, 16'hFFFF);
        write_reg(CFG_TASK_COUNT, 16'd15);
        send_item(mk_entry(3'd0, KIND_STRAIGHT, 16'hFFFF));
        send_item(mk_entry(3'd1, KIND_BAD, 16'hFFFF));
        send_item(mk_entry(3'd7, KIND_BACK, 16'd0));
        send_item(mk_step('1, '1, '1));
        send_item(mk_step(32'd65533, 32'd0, 32'd0));
        send_item(mk_step(32'd0, 32'd0, 32'd0));
        send_item(mk_step('1, '1, 32'd5));
        // drop the count below the stuck task
        write_reg(CFG_TASK_COUNT, 16'd1);
        send_item(mk_step(32'd0, 32'd0, 32'd6));
    endtask

    task automatic t_zero_count();
        write_reg(CFG_TASK_COUNT, 16'd0);
        send_item(mk_step(32'd7, 32'd7, 32'd7));
        send_item(mk_step(32'd8, 32'd8, 32'd8));
    endtask

    task automatic t_random();
        int          n;
        int          next_phase;
        int          roll;
        logic [15:0] val;
        n          = 0;
        next_phase = 0;
        wheel_l    = $urandom;
        wheel_r    = $urandom;
        ms_tick    = $urandom;
        while (n < RANDOM_ITEMS)
        begin
            if (n >= next_phase)
            begin
                next_phase += PHASE_LEN;
                roll = $urandom_range(9);
                val  = (roll == 0) ? 16'd0 : (roll == 1) ? 16'd8 : (roll == 2) ? 16'd15 :
                       16'($urandom_range(1, 6));
                write_reg(CFG_TASK_COUNT, val);
                roll = $urandom_range(9);
                val  = (roll == 0) ? 16'd0 : (roll == 1) ? 16'hFFFF : 16'($urandom_range(1, 80));
                write_reg(CFG_PAUSE_TICKS, val);
                roll = $urandom_range(9);
                val  = (roll == 0) ? 16'd0 : (roll == 1) ? 16'hFFFF :
                       16'($urandom_range(2000, 30000));
                write_reg(CFG_MM_SCALE, val);
                roll = $urandom_range(9);
                val  = (roll == 0) ? 16'd0 : (roll == 1) ? 16'hFFFF :
                       16'($urandom_range(2000, 30000));
                write_reg(CFG_DEGREE_SCALE, val);
                for (int s = 0; s < TABLE_DEPTH; s++)
                begin
                    send_item(mk_entry(3'(s),
                        ($urandom_range(99) < 8) ? 3'($urandom_range(4, 7)) :
                                                   3'($urandom_range(0, 3)),
                        ($urandom_range(19) == 0) ? 16'($urandom_range(65535)) :
                                                    16'($urandom_range(0, 250))));
                    n++;
                end
            end
            if (n >= 800 && n < 1200)
            begin
                gap_pct    = 0;
                stall_pct <= 0;
            end
            else
            begin
                gap_pct    = 6;
                stall_pct <= 6;
            end
            roll = $urandom_range(99);
            if (roll < 1)
            begin
                send_item(rand_item(FUNC_RESET));
                n++;
            end
            else if (roll < 3)
            begin
                send_item(rand_item(FUNC_SPARE));
            end
            else if (roll < 6)
            begin
                send_item(rand_item(FUNC_WRITE));
                n++;
            end
            else
            begin
                send_item(next_step());
                n++;
            end
        end
    endtask

    task automatic t_backpressure();
        holds_asked <= holds_asked + 1;
        repeat (HOLD_LEN) send_item(next_step());
    endtask

    initial
    begin
        p_count     = TASK_COUNT_RST;
        p_pause     = PAUSE_TICKS_RST;
        p_mm_scale  = MM_SCALE_RST;
        p_deg_scale = DEGREE_SCALE_RST;
        for (int s = 0; s < TABLE_DEPTH; s++)
        begin
            p_kind[s]   = KIND_STRAIGHT;
            p_amount[s] = 16'd0;
        end
        p_kind[1]    = KIND_RIGHT;
        p_kind[3]    = KIND_LEFT;
        p_amount[0]  = 16'd425;
        p_amount[1]  = 16'd150;
        p_amount[2]  = 16'd250;
        p_amount[3]  = 16'd45;
        p_amount[4]  = 16'd160;
        p_goal_l     = '0;
        p_goal_r     = '0;
        p_pause_from = '0;
        seq_idle();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        t_default_route();
        t_extremes();
        t_zero_count();
        t_random();
        t_backpressure();

        wait_idle();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
